[src/byte_ring_fifo_with_delimiter_read_core_assert.svh]
// Assertion macros for the byte ring FIFO checker.
`ifndef BYTE_RING_FIFO_WITH_DELIMITER_READ_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_DELIMITER_READ_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte ring fifo check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte ring fifo check failed");

`endif

[src/brfifo_pkg.sv]
// Package: shared constants and codes of the byte ring FIFO.
`timescale 1ns / 1ps
package brfifo_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int AMOUNT_W = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;

    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_BLOCK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELIM  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd4;

endpackage

[src/brfifo_if.sv]
// Interfaces: request and response channels of the byte ring FIFO.
`timescale 1ns / 1ps
interface brfifo_req_if;
    logic                              valid;
    logic                              ready;
    logic [brfifo_pkg::ACTION_W-1:0]   action;
    logic [brfifo_pkg::BYTE_W-1:0]     data_byte;
    logic [brfifo_pkg::AMOUNT_W-1:0]   amount;
    logic [brfifo_pkg::BYTE_W-1:0]     delimiter;

    modport source (output valid, action, data_byte, amount, delimiter, input ready);
    modport sink   (input valid, action, data_byte, amount, delimiter, output ready);
endinterface

interface brfifo_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [brfifo_pkg::BYTE_W-1:0]     read_byte;
    logic                              last;
    logic [brfifo_pkg::STATUS_W-1:0]   status;
    logic [brfifo_pkg::COUNT_W-1:0]    readable_count;
    logic [brfifo_pkg::COUNT_W-1:0]    writable_count;

    modport source (output valid, read_byte, last, status, readable_count, writable_count,
                    input ready);
    modport sink   (input valid, read_byte, last, status, readable_count, writable_count,
                    output ready);
endinterface

[src/brfifo_store.sv]
// Byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module brfifo_store #(
    parameter int DEPTH = brfifo_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [brfifo_pkg::BYTE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [brfifo_pkg::BYTE_W-1:0] rd_data
);

    logic [brfifo_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [brfifo_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/brfifo_step.sv]
// Shared pointer step: increment with wrap at the last slot.
`timescale 1ns / 1ps
module brfifo_step #(
    parameter int DEPTH = brfifo_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic [AW-1:0] ptr,
    output logic [AW-1:0] ptr_inc
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    assign ptr_inc = (ptr == LAST) ? '0 : ptr + AW'(1);

endmodule

[src/byte_ring_fifo_with_delimiter_read_core.sv]
// Top level: sequencer of the circular byte FIFO with block and delimiter reads.
//
// Usage: one request transaction on req carries an action (write, read one,
// read block, read to delimiter, query) with its byte, amount and delimiter.
// Each request yields one or more response transactions on rsp; the final one
// of a run has last set, and every response carries the readable and
// writable counts as they stand after it. The FIFO holds up to DEPTH-1 bytes.
// req.ready is high only while the sequencer is idle; one request is worked
// on at a time.
// Flow: write, single-result answers and query pass from acceptance
// through the emit state to the response register; a single read passes
// through the read-address and read-data states. Block and delimiter runs
// give each byte by a store read and a data state through the one store read
// port; the delimiter scan first inspects bytes, each inspected byte needing
// a store read and a compare of the registered data.
// Reset: pointers and count clear, the FIFO is empty, no response is pending.
// Store contents are not cleared; only written slots are ever read.
// Stall: a response waits in the output register until rsp.ready; the
// sequencer holds its run until the register frees.
`timescale 1ns / 1ps
module byte_ring_fifo_with_delimiter_read_core #(
    parameter int DEPTH = brfifo_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    brfifo_req_if.sink    req,
    brfifo_rsp_if.source  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] CAP = AW'(DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EMIT    = 6'b000010,
        S_RD_ADDR = 6'b000100,
        S_RD_DATA = 6'b001000,
        S_SC_ADDR = 6'b010000,
        S_SC_CMP  = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [AW-1:0]                     rp_reg, rp_next;
    logic [AW-1:0]                     wp_reg, wp_next;
    logic [AW-1:0]                     cnt_reg, cnt_next;
    logic [AW-1:0]                     remain_reg, remain_next;
    logic [AW-1:0]                     scan_ptr_reg, scan_ptr_next;
    logic [AW-1:0]                     scan_idx_reg, scan_idx_next;
    logic [brfifo_pkg::BYTE_W-1:0]     delim_reg, delim_next;
    logic [brfifo_pkg::STATUS_W-1:0]   pend_reg, pend_next;

    logic                              ov_reg, ov_next;
    logic [brfifo_pkg::BYTE_W-1:0]     obyte_reg, obyte_next;
    logic                              olast_reg, olast_next;
    logic [brfifo_pkg::STATUS_W-1:0]   ostat_reg, ostat_next;
    logic [brfifo_pkg::COUNT_W-1:0]    ordc_reg, ordc_next;
    logic [brfifo_pkg::COUNT_W-1:0]    owrc_reg, owrc_next;

    logic                              wr_en, rd_en;
    logic [AW-1:0]                     rd_addr;
    logic [brfifo_pkg::BYTE_W-1:0]     rd_data;
    logic [AW-1:0]                     step_in, step_out;
    logic                              slot_free;
    logic [brfifo_pkg::AMOUNT_W-1:0]   cnt_ext;
    logic [AW-1:0]                     blk_n;
    logic [AW-1:0]                     idx_inc;

    brfifo_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (req.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    brfifo_step #(.DEPTH(DEPTH), .AW(AW)) u_step (
        .ptr     (step_in),
        .ptr_inc (step_out)
    );

    assign slot_free = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    // amount saturates to the held count
    assign cnt_ext = brfifo_pkg::AMOUNT_W'(cnt_reg);
    assign blk_n   = (req.amount < cnt_ext) ? AW'(req.amount) : cnt_reg;
    assign idx_inc = scan_idx_reg + AW'(1);

    always_comb
    begin
        case (state_reg)
            S_IDLE:    step_in = wp_reg;
            S_SC_CMP:  step_in = scan_ptr_reg;
            default:   step_in = rp_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        cnt_next      = cnt_reg;
        remain_next   = remain_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_idx_next = scan_idx_reg;
        delim_next    = delim_reg;
        pend_next     = pend_reg;
        ov_next       = ov_reg && !rsp.ready;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;
        ostat_next    = ostat_reg;
        ordc_next     = ordc_reg;
        owrc_next     = owrc_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = rp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    delim_next = req.delimiter;
                    state_next = S_EMIT;
                    pend_next  = brfifo_pkg::ST_DONE;
                    case (req.action)
                        brfifo_pkg::ACT_WRITE:
                        begin
                            if (cnt_reg == CAP)
                            begin
                                pend_next = brfifo_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wp_next  = step_out;
                                cnt_next = cnt_reg + AW'(1);
                            end
                        end
                        brfifo_pkg::ACT_READ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_next = brfifo_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                remain_next = AW'(1);
                                state_next  = S_RD_ADDR;
                            end
                        end
                        brfifo_pkg::ACT_BLOCK:
                        begin
                            if (blk_n == '0)
                            begin
                                pend_next = brfifo_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                remain_next = blk_n;
                                state_next  = S_RD_ADDR;
                            end
                        end
                        brfifo_pkg::ACT_DELIM:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_next = brfifo_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                scan_ptr_next = rp_reg;
                                scan_idx_next = '0;
                                state_next    = S_SC_ADDR;
                            end
                        end
                        default:
                        begin
                            pend_next = brfifo_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    obyte_next = '0;
                    olast_next = 1'b1;
                    ostat_next = pend_reg;
                    ordc_next  = brfifo_pkg::COUNT_W'(cnt_reg);
                    owrc_next  = brfifo_pkg::COUNT_W'(CAP - cnt_reg);
                    state_next = S_IDLE;
                end
            end
            S_RD_ADDR:
            begin
                // pop: count and pointer move now, byte shows next cycle
                rd_en       = 1'b1;
                rd_addr     = rp_reg;
                rp_next     = step_out;
                cnt_next    = cnt_reg - AW'(1);
                remain_next = remain_reg - AW'(1);
                state_next  = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    obyte_next = rd_data;
                    olast_next = (remain_reg == '0);
                    ostat_next = brfifo_pkg::ST_DELIVERED;
                    ordc_next  = brfifo_pkg::COUNT_W'(cnt_reg);
                    owrc_next  = brfifo_pkg::COUNT_W'(CAP - cnt_reg);
                    state_next = (remain_reg == '0) ? S_IDLE : S_RD_ADDR;
                end
            end
            S_SC_ADDR:
            begin
                rd_en      = 1'b1;
                rd_addr    = scan_ptr_reg;
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                if (rd_data == delim_reg)
                begin
                    remain_next = idx_inc;
                    state_next  = S_RD_ADDR;
                end
                else if (idx_inc == cnt_reg)
                begin
                    pend_next  = brfifo_pkg::ST_ABSENT;
                    state_next = S_EMIT;
                end
                else
                begin
                    scan_idx_next = idx_inc;
                    scan_ptr_next = step_out;
                    state_next    = S_SC_ADDR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rp_reg    <= '0;
            wp_reg    <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg   <= remain_next;
        scan_ptr_reg <= scan_ptr_next;
        scan_idx_reg <= scan_idx_next;
        delim_reg    <= delim_next;
        pend_reg     <= pend_next;
        obyte_reg    <= obyte_next;
        olast_reg    <= olast_next;
        ostat_reg    <= ostat_next;
        ordc_reg     <= ordc_next;
        owrc_reg     <= owrc_next;
    end

    assign rsp.valid          = ov_reg;
    assign rsp.read_byte      = obyte_reg;
    assign rsp.last           = olast_reg;
    assign rsp.status         = ostat_reg;
    assign rsp.readable_count = ordc_reg;
    assign rsp.writable_count = owrc_reg;

endmodule

[src/brfifo_chk.sv]
// Checker: port-level assertions for the byte ring FIFO, bound to the top level.
`timescale 1ns / 1ps
`include "byte_ring_fifo_with_delimiter_read_core_assert.svh"
module brfifo_chk #(
    parameter int DEPTH = brfifo_pkg::DEPTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [brfifo_pkg::BYTE_W-1:0]   read_byte,
    input logic                            last,
    input logic [brfifo_pkg::STATUS_W-1:0] status,
    input logic [brfifo_pkg::COUNT_W-1:0]  readable_count,
    input logic [brfifo_pkg::COUNT_W-1:0]  writable_count
);

    localparam logic [brfifo_pkg::COUNT_W:0] CAP = (brfifo_pkg::COUNT_W + 1)'(DEPTH - 1);

    logic [brfifo_pkg::COUNT_W:0] count_sum;
    logic                         no_byte;
    logic                         rsp_stall;
    logic [brfifo_pkg::BYTE_W+brfifo_pkg::STATUS_W:0] rsp_word;

    assign count_sum = {1'b0, readable_count} + {1'b0, writable_count};
    assign no_byte   = (status != brfifo_pkg::ST_DELIVERED);
    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_word  = {read_byte, status, last};

    `BRF_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word))
    `BRF_ASSERT_NOW(a_count_sum, rsp_valid, count_sum == CAP)
    `BRF_ASSERT_NOW(a_nobyte_single, rsp_valid && no_byte, last && read_byte == '0)
    `BRF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

bind byte_ring_fifo_with_delimiter_read_core brfifo_chk #(.DEPTH(DEPTH)) u_brfifo_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .read_byte      (rsp.read_byte),
    .last           (rsp.last),
    .status         (rsp.status),
    .readable_count (rsp.readable_count),
    .writable_count (rsp.writable_count)
);
